FILE: rtl/core/mrot90_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the 90-degree matrix rotation block.
package mrot90_pkg;

  // Default largest matrix dimension.
  localparam int MAX_DIM_DEF = 8;

  // Width of one matrix element.
  localparam int DATA_W = 32;

  // Width and reset value of the matrix size register.
  localparam int SIZE_W = 4;
  localparam logic [SIZE_W-1:0] SIZE_RST = 4'd4;

  // Configuration bus widths and the register index decode.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_MATRIX_SIZE = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_last;
  } cmd_t;

endpackage

FILE: rtl/core/mrot90_ctrl.sv
`timescale 1ns / 1ps
// Controller: load counter, read-out scan and the load/read state machine.
module mrot90_ctrl #(
  parameter int MAX_DIM = mrot90_pkg::MAX_DIM_DEF,
  parameter int DEPTH   = MAX_DIM * MAX_DIM,
  parameter int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mrot90_pkg::SIZE_W-1:0]  matrix_size,
  output logic                           busy,
  output logic [ADDR_W-1:0]              wr_addr,
  output logic [ADDR_W-1:0]              rd_addr,
  output mrot90_pkg::cmd_t               cmd
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int TOT_W = $clog2(DEPTH + 1);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic              state_r, state_nxt;
  logic [ADDR_W-1:0] count_r, count_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] src_r, src_nxt;

  logic [DIM_W-1:0]  n_eff;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  count_inc;
  logic [ADDR_W-1:0] top_base;
  logic [ADDR_W-1:0] n_addr;
  logic              row_end;
  logic              scan_last;
  logic              accept;

  // Clamp the configured size into 1..MAX_DIM.
  always_comb begin
    if (matrix_size == '0) begin
      n_eff = DIM_W'(1);
    end else if (matrix_size > mrot90_pkg::SIZE_W'(MAX_DIM)) begin
      n_eff = DIM_W'(MAX_DIM);
    end else begin
      n_eff = matrix_size[DIM_W-1:0];
    end
  end

  // Element count and the address of the first element of the bottom row.
  assign total     = TOT_W'(n_eff) * TOT_W'(n_eff);
  assign top_base  = ADDR_W'(total - TOT_W'(n_eff));
  assign n_addr    = ADDR_W'(n_eff);
  assign count_inc = TOT_W'(count_r) + TOT_W'(1);

  assign row_end   = (col_r == n_eff - DIM_W'(1));
  assign scan_last = row_end && (row_r == n_eff - DIM_W'(1));
  assign accept    = start && (state_r == ST_LOAD);

  assign busy    = (state_r == ST_READ);
  assign wr_addr = count_r;
  assign rd_addr = src_r;

  assign cmd.wr_en   = accept;
  assign cmd.rd_en   = (state_r == ST_READ);
  assign cmd.rd_last = (state_r == ST_READ) && scan_last;

  // Next-state logic: load words until the matrix is full, then scan it
  // column by column from the bottom row up.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    src_nxt   = src_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (count_inc >= total) begin
            count_nxt = '0;
            state_nxt = ST_READ;
            row_nxt   = '0;
            col_nxt   = '0;
            src_nxt   = top_base;
          end else begin
            count_nxt = count_inc[ADDR_W-1:0];
          end
        end
      end
      ST_READ: begin
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + DIM_W'(1);
          src_nxt = top_base + ADDR_W'(row_r) + ADDR_W'(1);
        end else begin
          col_nxt = col_r + DIM_W'(1);
          src_nxt = src_r - n_addr;
        end
        if (scan_last) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
      row_r   <= '0;
      col_r   <= '0;
      src_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      src_r   <= src_nxt;
    end
  end

endmodule

FILE: rtl/core/mrot90_datapath.sv
`timescale 1ns / 1ps
// Datapath: element memory, registered read port and result word register.
module mrot90_datapath #(
  parameter int MAX_DIM = mrot90_pkg::MAX_DIM_DEF,
  parameter int DEPTH   = MAX_DIM * MAX_DIM,
  parameter int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mrot90_pkg::cmd_t                      cmd,
  input  logic [ADDR_W-1:0]                     wr_addr,
  input  logic [ADDR_W-1:0]                     rd_addr,
  input  logic signed [mrot90_pkg::DATA_W-1:0]  wr_data,
  output logic signed [mrot90_pkg::DATA_W-1:0]  rd_data,
  output logic                                  rd_valid,
  output logic                                  rd_last
);

  logic [mrot90_pkg::DATA_W-1:0] mem [DEPTH];
  logic [mrot90_pkg::DATA_W-1:0] rd_data_r;
  logic                          valid_r;
  logic                          last_r;

  // Element memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result strobe and last-word flag are registered from the read commands, in step with the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= cmd.rd_en;
      last_r  <= cmd.rd_last;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = valid_r;
  assign rd_last  = last_r;

endmodule

FILE: rtl/core/matrix_rotate_90_clockwise_top.sv
`timescale 1ns / 1ps
// Top level of the 90-degree clockwise matrix rotation block.
// A word is loaded whenever start is high and busy is low; busy stays low while a matrix loads.
// The word that completes an n-by-n matrix starts the read-out of all n*n words,
// one result word per cycle; the first reaches the ports after the state register
// has entered read and the read port has registered it. Results cannot be stalled.
// Synchronous active-low reset clears the controller and sets the size to 4.
module matrix_rotate_90_clockwise_top #(
  parameter int MAX_DIM = mrot90_pkg::MAX_DIM_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // Input channel
  input  logic                                      start,
  output logic                                      busy,
  input  logic signed [mrot90_pkg::DATA_W-1:0]      in_element_value,
  // Result channel
  output logic                                      out_valid,
  output logic signed [mrot90_pkg::DATA_W-1:0]      out_rotated_value,
  output logic                                      out_is_last,
  // Configuration port
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [mrot90_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [mrot90_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [mrot90_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                      pready
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [mrot90_pkg::SIZE_W-1:0] size_r;
  logic                          cfg_sel;
  logic                          cfg_write;
  mrot90_pkg::cmd_t              cmd;
  logic [ADDR_W-1:0]             wr_addr;
  logic [ADDR_W-1:0]             rd_addr;

  // Configuration register decode.
  assign pready    = 1'b1;
  assign cfg_sel   = (paddr[2] == mrot90_pkg::REG_MATRIX_SIZE);
  assign cfg_write = psel && penable && pwrite && pready && cfg_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= mrot90_pkg::SIZE_RST;
    end else if (cfg_write) begin
      size_r <= pwdata[mrot90_pkg::SIZE_W-1:0];
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    if (cfg_sel) begin
      prdata = mrot90_pkg::CFG_DATA_W'(size_r);
    end
  end

  // Controller.
  mrot90_ctrl #(
    .MAX_DIM (MAX_DIM),
    .DEPTH   (DEPTH),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .matrix_size (size_r),
    .busy        (busy),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .cmd         (cmd)
  );

  // Datapath.
  mrot90_datapath #(
    .MAX_DIM (MAX_DIM),
    .DEPTH   (DEPTH),
    .ADDR_W  (ADDR_W)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .wr_data  (in_element_value),
    .rd_data  (out_rotated_value),
    .rd_valid (out_valid),
    .rd_last  (out_is_last)
  );

endmodule
